>>> src/two_generation_dedup_filter_unit_assert.svh
// Assertion macros shared by the dedup filter RTL.
`ifndef TWO_GENERATION_DEDUP_FILTER_UNIT_ASSERT_SVH
`define TWO_GENERATION_DEDUP_FILTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define TGDF_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TGDF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGDF_ASSERT_RST(label, clk, rst, prop, msg)
`define TGDF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> src/tgdf_pkg.sv
package tgdf_pkg;

   localparam int GEN_DEPTH = 256;
   localparam int KEY_W     = 64;
   localparam int LIMIT_W   = 9;
   localparam int ADDR_W    = $clog2(2 * GEN_DEPTH);
   localparam int FILL_W    = $clog2(GEN_DEPTH + 1);
   localparam int CMP_W     = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(256);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
   } mem_cmd_type;

   typedef struct packed {
      logic load_key;
      logic cmp_en;
      logic rsp_load;
   } dp_ctrl_type;

   // Zero acts as one, anything above the generation depth saturates.
   function automatic logic [FILL_W-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
      logic [CMP_W-1:0] l;
      l = CMP_W'(lim);
      if (l == '0) begin
         l = CMP_W'(1);
      end
      if (l > CMP_W'(GEN_DEPTH)) begin
         l = CMP_W'(GEN_DEPTH);
      end
      return FILL_W'(l);
   endfunction

endpackage

>>> src/tgdf_ram.sv
module tgdf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tgdf_ctrl.sv
`include "two_generation_dedup_filter_unit_assert.svh"

module tgdf_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tgdf_pkg::LIMIT_W-1:0] csr_generation_limit,
   input  logic                         rsp_free,
   input  logic                         hit,
   output tgdf_pkg::mem_cmd_type        mem,
   output tgdf_pkg::dp_ctrl_type        dp
);

   tgdf_pkg::state_type                state_ff, state_in;
   logic [tgdf_pkg::FILL_W-1:0]        idx_ff, idx_in;
   logic                               pass_ff, pass_in;
   logic                               rd_pend_ff, rd_pend_in;
   logic [tgdf_pkg::FILL_W-1:0]        fill_ff [2];
   logic [tgdf_pkg::FILL_W-1:0]        fill_in [2];
   logic                               active_ff, active_in;
   logic [tgdf_pkg::LIMIT_W-1:0]       limit_ff;

   logic                               bank_phys;
   logic [tgdf_pkg::FILL_W-1:0]        scan_n;
   logic [tgdf_pkg::FILL_W-1:0]        lim_eff;
   logic                               wr_bank;
   logic [tgdf_pkg::FILL_W-1:0]        wr_slot;

   assign csr_ready = 1'b1;
   assign bank_phys = active_ff ^ pass_ff;
   assign scan_n    = fill_ff[bank_phys];
   assign lim_eff   = tgdf_pkg::eff_limit(limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tgdf_pkg::ST_IDLE;
         idx_ff     <= '0;
         pass_ff    <= 1'b0;
         rd_pend_ff <= 1'b0;
         fill_ff[0] <= '0;
         fill_ff[1] <= '0;
         active_ff  <= 1'b0;
         limit_ff   <= tgdf_pkg::LIMIT_RESET;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         pass_ff    <= pass_in;
         rd_pend_ff <= rd_pend_in;
         fill_ff[0] <= fill_in[0];
         fill_ff[1] <= fill_in[1];
         active_ff  <= active_in;
         if (csr_valid) begin
            limit_ff <= csr_generation_limit;
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pass_in     = pass_ff;
      rd_pend_in  = 1'b0;
      fill_in[0]  = fill_ff[0];
      fill_in[1]  = fill_ff[1];
      active_in   = active_ff;
      req_ready   = 1'b0;
      mem         = '0;
      dp          = '0;
      dp.cmp_en   = rd_pend_ff;
      wr_bank     = active_ff;
      wr_slot     = fill_ff[active_ff];

      case (state_ff)
         tgdf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp.load_key = 1'b1;
               idx_in      = '0;
               pass_in     = 1'b0;
               state_in    = tgdf_pkg::ST_SCAN;
            end
         end
         tgdf_pkg::ST_SCAN: begin
            if (idx_ff < scan_n) begin
               mem.rd_en   = 1'b1;
               mem.rd_addr = bank_phys
                  ? tgdf_pkg::ADDR_W'(tgdf_pkg::GEN_DEPTH) + tgdf_pkg::ADDR_W'(idx_ff)
                  : tgdf_pkg::ADDR_W'(idx_ff);
               rd_pend_in  = 1'b1;
               idx_in      = idx_ff + tgdf_pkg::FILL_W'(1);
            end else if (!pass_ff) begin
               // advance to the other generation
               pass_in = 1'b1;
               idx_in  = '0;
            end else begin
               state_in = tgdf_pkg::ST_DONE;
            end
         end
         tgdf_pkg::ST_DONE: begin
            if (rsp_free) begin
               dp.rsp_load = 1'b1;
               state_in    = tgdf_pkg::ST_IDLE;
               if (!hit) begin
                  if (fill_ff[active_ff] >= lim_eff) begin
                     // rotate: the full generation becomes previous
                     wr_bank   = ~active_ff;
                     wr_slot   = '0;
                     active_in = ~active_ff;
                  end
                  mem.wr_en        = 1'b1;
                  mem.wr_addr      = wr_bank
                     ? tgdf_pkg::ADDR_W'(tgdf_pkg::GEN_DEPTH) + tgdf_pkg::ADDR_W'(wr_slot)
                     : tgdf_pkg::ADDR_W'(wr_slot);
                  fill_in[wr_bank] = wr_slot + tgdf_pkg::FILL_W'(1);
               end
            end
         end
         default: begin
            state_in = tgdf_pkg::ST_IDLE;
         end
      endcase
   end

   `TGDF_ASSERT_RST(a_fill_bound, clock, reset, (fill_ff[0] <= tgdf_pkg::FILL_W'(tgdf_pkg::GEN_DEPTH) && fill_ff[1] <= tgdf_pkg::FILL_W'(tgdf_pkg::GEN_DEPTH)), "generation fill above depth")
   `TGDF_ASSERT_RST(a_rd_in_scan, clock, reset, (rd_pend_ff |-> state_ff == tgdf_pkg::ST_SCAN), "read data returned outside scan")
   `TGDF_ASSERT_RST(a_wr_new_only, clock, reset, (mem.wr_en |-> (!hit && state_ff == tgdf_pkg::ST_DONE)), "insert without a miss")
   `TGDF_ASSERT_RST(a_wr_fill, clock, reset, (mem.wr_en |=> fill_ff[active_ff] != '0), "active generation empty after insert")

endmodule

>>> src/two_generation_dedup_filter_unit.sv
// Duplicate filter over 64-bit keys, kept in two generations of up to GEN_DEPTH keys
// (256) each. For every key on req_ the block answers one word on rsp_: seen is 1
// if the key is held in either generation, else 0 and the key is appended to the
// active generation; when the active generation already holds generation_limit
// keys (0 acts as 1, values above GEN_DEPTH saturate) it becomes previous and the
// old previous is dropped. All keys sit in one single-port-read memory that is
// scanned one entry and one 64-bit compare per cycle, so a key is answered after the
// filled entries of both generations are scanned, plus any wait for a result still
// held in the output register; req_ready is low meanwhile. No clearing pass follows
// reset. csr_ writes are taken at any time and are meant for an idle block.
`include "two_generation_dedup_filter_unit_assert.svh"

module two_generation_dedup_filter_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [tgdf_pkg::KEY_W-1:0]   req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_seen,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [tgdf_pkg::LIMIT_W-1:0] csr_generation_limit
);

   tgdf_pkg::mem_cmd_type         mem;
   tgdf_pkg::dp_ctrl_type         dp;
   logic [tgdf_pkg::KEY_W-1:0]    key_ff;
   logic [tgdf_pkg::KEY_W-1:0]    rd_data;
   logic                          hit_ff, hit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_seen_ff;
   logic                          rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   tgdf_ctrl u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_generation_limit (csr_generation_limit),
      .rsp_free             (rsp_free),
      .hit                  (hit_ff),
      .mem                  (mem),
      .dp                   (dp)
   );

   tgdf_ram #(
      .WIDTH (tgdf_pkg::KEY_W),
      .DEPTH (2 * tgdf_pkg::GEN_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (key_ff),
      .rd_en   (mem.rd_en),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      hit_in = hit_ff;
      if (dp.load_key) begin
         hit_in = 1'b0;
      end else if (dp.cmp_en && rd_data == key_ff) begin
         hit_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (dp.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp.load_key) begin
         key_ff <= req_key;
      end
      if (dp.rsp_load) begin
         rsp_seen_ff <= hit_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_seen  = rsp_seen_ff;

   `TGDF_ASSERT_RST(a_rsp_no_overwrite, clock, reset, (dp.rsp_load |-> (!rsp_valid_ff || rsp_ready)), "result word overwritten")

endmodule
